@@ src/aip_pkg.sv @@
// Shared types, character codes and digit decode for the ASCII integer parser.
// No dependencies; imported by aip_step, ascii_integer_parser and the bench.
package aip_pkg;

    // Width of the accumulated value
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = 8;
    localparam int BASE_W      = 5;
    localparam int CH_W        = 8;

    // Output stream tdata: value, then end_offset, padded to bytes
    localparam int OUT_DATA_W  = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic CFG_BASE_SELECT = 1'b0;
    localparam logic CFG_SIGNED_MODE = 1'b1;

    // Character codes
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [CH_W-1:0] CH_X     = 8'h78;  // 'x'
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;  // '-'

    // Bases
    localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_XPEND  = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic [VALUE_WIDTH-1:0]  acc;
        logic [BASE_W-1:0]       base;
        logic                    neg;
        logic [CNT_W-1:0]        cnt;
    } parse_state_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    // Hex digit decode; ok is low for anything outside 0-9, a-f, A-F
    function automatic hex_digit_t hex_value(input logic [CH_W-1:0] c);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d.val = 4'(c - CH_ZERO);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            d.val = 4'(c - CH_LA) + 4'd10;
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            d.val = 4'(c - CH_UA) + 4'd10;
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

@@ src/aip_step.sv @@
// Next-state logic of the parser: prefix handling, base choice and one
// multiply-add per character. Depends on aip_pkg.
module aip_step
    import aip_pkg::*;
(
    input  parse_state_t            cur,
    input  logic                    start_req,
    input  logic [CH_W-1:0]         ch,
    input  logic [BASE_W-1:0]       base_select,
    input  logic                    signed_mode,
    output parse_state_t            nxt,
    output logic [VALUE_WIDTH-1:0]  value
);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    hex_digit_t              hd;
    parse_state_t            mid;
    logic                    take;
    logic [VALUE_WIDTH-1:0]  prod;

    assign hd = hex_value(ch);

    // Prefix and phase handling; decides whether this character is a digit try
    always_comb
    begin
        mid  = cur;
        take = 1'b0;
        if (start_req)
        begin
            mid.acc   = '0;
            mid.base  = '0;
            mid.neg   = 1'b0;
            mid.cnt   = '0;
            mid.phase = PH_LEAD;
        end
        if (start_req && signed_mode && ch == CH_MINUS)
        begin
            mid.neg = 1'b1;
            mid.cnt = sat_inc(mid.cnt);
        end
        else
        begin
            unique case (mid.phase)
                PH_LEAD:
                begin
                    if (ch == CH_ZERO)
                    begin
                        mid.cnt   = sat_inc(mid.cnt);
                        mid.phase = PH_ZERO;
                    end
                    else
                    begin
                        mid.base  = (base_select != '0) ? base_select : BASE_DEC;
                        mid.phase = PH_DIGITS;
                        take      = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (ch == CH_X)
                    begin
                        mid.phase = PH_XPEND;
                    end
                    else
                    begin
                        mid.base  = (base_select != '0) ? base_select : BASE_OCT;
                        mid.phase = PH_DIGITS;
                        take      = 1'b1;
                    end
                end
                PH_XPEND:
                begin
                    // the pending 'x' counts only if a hex digit follows
                    if (hd.ok)
                    begin
                        mid.base  = BASE_HEX;
                        mid.cnt   = sat_inc(mid.cnt);
                        mid.phase = PH_DIGITS;
                        take      = 1'b1;
                    end
                    else
                    begin
                        mid.base  = (base_select != '0) ? base_select : BASE_OCT;
                        mid.phase = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    take = 1'b1;
                end
                PH_IDLE, PH_DONE:
                begin
                    take = 1'b0;
                end
                default:
                begin
                    take = 1'b0;
                end
            endcase
        end
    end

    // Single shared multiply-add for the digit
    assign prod = mid.acc * VALUE_WIDTH'(mid.base);

    always_comb
    begin
        nxt = mid;
        if (take)
        begin
            if (hd.ok && ({1'b0, hd.val} < mid.base))
            begin
                nxt.acc = prod + VALUE_WIDTH'(hd.val);
                nxt.cnt = sat_inc(mid.cnt);
            end
            else
            begin
                nxt.phase = PH_DONE;
            end
        end
    end

    // Reported value, negated when a minus was taken
    assign value = nxt.neg ? (VALUE_WIDTH'(0) - nxt.acc) : nxt.acc;

endmodule

@@ src/ascii_integer_parser.sv @@
// ASCII-to-integer parser, one character per beat, with auto base detection.
// Top level: config registers, parse state and output register.
// Depends on aip_pkg and aip_step.
//
// Usage:
//   s_axis carries one character per beat; tuser marks the first character
//   of a new string. Every accepted beat yields exactly one m_axis beat with
//   the running value, the done flag and the consumed-character count.
//   cfg_we/cfg_addr/cfg_wdata write base_select (index 0, 0 = automatic)
//   and signed_mode (index 1); write them only while the stream is idle.
// The result beat is registered; it appears in the cycle after its input beat is accepted.
// Throughput: one character per cycle if m_axis is not stalled; the state
//   update (one multiply by the 5-bit base plus digit add) is combinational.
// Reset: base automatic, unsigned mode, parser idle with value zero; no
//   result is pending.
// Stall: a pending result holds while m_axis_tready is low, and input is
//   refused only then; it reloads in the same cycle the result is taken.
module ascii_integer_parser
    import aip_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic                    cfg_addr,
    input  logic [BASE_W-1:0]       cfg_wdata,
    // character stream in
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [CH_W-1:0]         s_axis_tdata,   // [7:0] ch
    input  logic                    s_axis_tuser,   // [0] start_req
    // result stream out
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // value, then end_offset
    output logic                    m_axis_tuser    // [0] done_res
);

    logic [BASE_W-1:0]       base_select_reg;
    logic                    signed_mode_reg;
    parse_state_t            state_reg;
    parse_state_t            state_next;
    logic [VALUE_WIDTH-1:0]  value_next;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_done_reg;
    logic                    in_beat;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_select_reg <= '0;
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BASE_SELECT: base_select_reg <= cfg_wdata;
                CFG_SIGNED_MODE: signed_mode_reg <= cfg_wdata[0];
                default:         base_select_reg <= base_select_reg;
            endcase
        end
    end

    aip_step u_step (
        .cur         (state_reg),
        .start_req   (s_axis_tuser),
        .ch          (s_axis_tdata),
        .base_select (base_select_reg),
        .signed_mode (signed_mode_reg),
        .nxt         (state_next),
        .value       (value_next)
    );

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= PH_IDLE;
            state_reg.acc   <= '0;
            state_reg.base  <= '0;
            state_reg.neg   <= 1'b0;
            state_reg.cnt   <= '0;
        end
        else if (in_beat)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            out_data_reg <= OUT_DATA_W'({state_next.cnt, value_next});
            out_done_reg <= (state_next.phase == PH_DONE);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_done_reg;

endmodule

@@ bench/aip_checker.sv @@
// Scoreboard for the ASCII integer parser: watches the config port and both streams.
// Predicts every result beat from the accepted characters and compares field by field.
// Depends on aip_pkg.
module aip_checker
    import aip_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_addr,
    input  logic [BASE_W-1:0]       cfg_wdata,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [CH_W-1:0]         s_axis_tdata,   // [7:0] ch
    input  logic                    s_axis_tuser,   // [0] start_req
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_DATA_W-1:0]   m_axis_tdata,   // [31:0] value, [39:32] end_offset
    input  logic                    m_axis_tuser,   // [0] done_res
    output int                      errors,
    output int                      pending
);

    localparam logic [4:0] NO_DIGIT = 5'h1F;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   done;
        logic [CNT_W-1:0]       offset;
    } parse_result_t;

    parse_result_t expected_q[$];

    // shadow of the config registers
    logic [BASE_W-1:0]      base_cfg;
    logic                   signed_cfg;

    // shadow of the parse state
    phase_t                 ph_q;
    logic [VALUE_WIDTH-1:0] acc_q;
    logic [BASE_W-1:0]      base_q;
    logic                   neg_q;
    logic [CNT_W-1:0]       cnt_q;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // digit value of a character, NO_DIGIT outside 0-9, a-f, A-F
    function automatic logic [4:0] digit_of(input logic [CH_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 5'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LF)
            return 5'(c - CH_LA) + 5'd10;
        if (c >= CH_UA && c <= CH_UF)
            return 5'(c - CH_UA) + 5'd10;
        return NO_DIGIT;
    endfunction

    function automatic logic [BASE_W-1:0] base_or(input logic [BASE_W-1:0] fallback);
        return (base_cfg != '0) ? base_cfg : fallback;
    endfunction

    // saturating character count
    task automatic bump_count();
        if (cnt_q != CNT_MAX)
            cnt_q = cnt_q + 1'b1;
    endtask

    task automatic take_digit(input logic [CH_W-1:0] c);
        logic [4:0] d;
        d = digit_of(c);
        if (d != NO_DIGIT && d < base_q)
        begin
            acc_q = acc_q * VALUE_WIDTH'(base_q) + VALUE_WIDTH'(d);
            bump_count();
        end
        else
        begin
            ph_q = PH_DONE;
        end
    endtask

    // one character through the parse phases
    task automatic advance(input logic [CH_W-1:0] c);
        case (ph_q)
            PH_LEAD:
            begin
                if (c == CH_ZERO)
                begin
                    bump_count();
                    ph_q = PH_ZERO;
                end
                else
                begin
                    base_q = base_or(BASE_DEC);
                    ph_q   = PH_DIGITS;
                    take_digit(c);
                end
            end
            PH_ZERO:
            begin
                if (c == CH_X)
                begin
                    ph_q = PH_XPEND;
                end
                else
                begin
                    base_q = base_or(BASE_OCT);
                    ph_q   = PH_DIGITS;
                    take_digit(c);
                end
            end
            PH_XPEND:
            begin
                // the pending 'x' counts only when a hex digit follows
                if (digit_of(c) != NO_DIGIT)
                begin
                    base_q = BASE_HEX;
                    bump_count();
                    ph_q   = PH_DIGITS;
                    take_digit(c);
                end
                else
                begin
                    base_q = base_or(BASE_OCT);
                    ph_q   = PH_DONE;
                end
            end
            PH_DIGITS:
                take_digit(c);
            default:
                ;
        endcase
    endtask

    task automatic predict_char(input logic start, input logic [CH_W-1:0] c);
        parse_result_t r;
        if (start)
        begin
            acc_q  = '0;
            base_q = '0;
            neg_q  = 1'b0;
            cnt_q  = '0;
            ph_q   = PH_LEAD;
            if (signed_cfg && c == CH_MINUS)
            begin
                neg_q = 1'b1;
                bump_count();
            end
            else
            begin
                advance(c);
            end
        end
        else
        begin
            advance(c);
        end
        r.value  = neg_q ? (~acc_q + 1'b1) : acc_q;
        r.done   = (ph_q == PH_DONE);
        r.offset = cnt_q;
        expected_q.push_back(r);
    endtask

    task automatic check_result();
        parse_result_t e;
        logic [VALUE_WIDTH-1:0] got_value;
        logic [CNT_W-1:0]       got_offset;
        got_value  = m_axis_tdata[VALUE_WIDTH-1:0];
        got_offset = m_axis_tdata[VALUE_WIDTH +: CNT_W];
        if (expected_q.size() == 0)
        begin
            $error("unexpected result beat: value %h done_res %b end_offset %0d",
                   got_value, m_axis_tuser, got_offset);
            errors++;
        end
        else
        begin
            e = expected_q.pop_front();
            if (got_value !== e.value)
            begin
                $error("value: expected %h, got %h", e.value, got_value);
                errors++;
            end
            if (m_axis_tuser !== e.done)
            begin
                $error("done_res: expected %b, got %b", e.done, m_axis_tuser);
                errors++;
            end
            if (got_offset !== e.offset)
            begin
                $error("end_offset: expected %0d, got %0d", e.offset, got_offset);
                errors++;
            end
        end
    endtask

    // results leave before new characters enter the shadow state
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg   = '0;
            signed_cfg = 1'b0;
            ph_q       = PH_IDLE;
            acc_q      = '0;
            base_q     = '0;
            neg_q      = 1'b0;
            cnt_q      = '0;
            expected_q.delete();
            pending    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                predict_char(s_axis_tuser, s_axis_tdata);
            if (cfg_we)
            begin
                if (cfg_addr == CFG_BASE_SELECT)
                    base_cfg = cfg_wdata;
                else if (cfg_addr == CFG_SIGNED_MODE)
                    signed_cfg = cfg_wdata[0];
            end
            pending = expected_q.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the ASCII integer parser bench: clock, reset, character stimulus and verdict.
// Instantiates ascii_integer_parser and aip_checker; depends on aip_pkg.
module tb_top;
    import aip_pkg::*;

    localparam int TARGET_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 10;
    localparam logic [CH_W-1:0] CH_LG = 8'h67;  // 'g'

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic                   cfg_addr;
    logic [BASE_W-1:0]      cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [CH_W-1:0]        s_axis_tdata;   // [7:0] ch
    logic                   s_axis_tuser;   // [0] start_req
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // [31:0] value, [39:32] end_offset
    logic                   m_axis_tuser;   // [0] done_res

    int  errors;
    int  pending;
    int  items_sent;
    int  cur_base;
    bit  cur_signed;
    bit  calm;

    ascii_integer_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    aip_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // gap length: mostly none or short, a few long; none during calm stretches
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [CH_W-1:0] digit_char(input int v);
        if (v < 10)
            return CH_ZERO + CH_W'(v);
        if ($urandom_range(0, 1))
            return CH_LA + CH_W'(v - 10);
        return CH_UA + CH_W'(v - 10);
    endfunction

    // one character beat, valid left high after acceptance
    task automatic send_char(input logic start, input logic [CH_W-1:0] c);
        int gap;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_str(input string s, input bit terminate);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(i == 0, CH_W'(s[i]));
        if (terminate)
            send_char(1'b0, 8'h00);
    endtask

    // hold off the sender until every expected result has been taken
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0 || m_axis_tvalid)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input int data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= BASE_W'(data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_mode(input int b, input bit sg);
        drain();
        write_cfg(CFG_BASE_SELECT, b);
        write_cfg(CFG_SIGNED_MODE, sg);
        cur_base   = b;
        cur_signed = sg;
    endtask

    // mostly well-formed numbers with random content, some noise and cut strings
    task automatic random_string();
        logic [CH_W-1:0] q[$];
        int kind, pre, eff, n, i, t;
        if ($urandom_range(0, 19) == 0)
            calm = ~calm;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                send_char(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0 || (!cur_signed && $urandom_range(0, 15) == 0))
            q.push_back(CH_MINUS);
        pre = $urandom_range(0, 9);
        if (pre >= 3)
            q.push_back(CH_ZERO);
        if (pre >= 6)
            q.push_back(CH_X);
        if (pre == 9)
            q.push_back(($urandom_range(0, 1)) ? CH_LG : CH_W'($urandom_range(0, 255)));
        if (pre >= 6)
            eff = 16;
        else if (cur_base != 0)
            eff = cur_base;
        else
            eff = (pre >= 3) ? 8 : 10;
        if (eff > 16)
            eff = 16;
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 12);
        for (i = 0; i < n; i++)
            q.push_back(digit_char($urandom_range(0, eff - 1)));
        t = $urandom_range(0, 4);
        case (t)
            0: q.push_back(8'h00);
            1: q.push_back(CH_W'($urandom_range(0, 255)));
            2: q.push_back((eff < 16) ? digit_char($urandom_range(eff, 15)) : CH_LG);
            default: ;
        endcase
        // characters after the stop are ignored
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                q.push_back(CH_W'($urandom_range(0, 255)));
        end
        // cut short: the next string starts in the middle of this one
        if ($urandom_range(0, 9) == 0 && q.size() > 1)
        begin
            n = $urandom_range(1, q.size() - 1);
            while (q.size() > n)
                void'(q.pop_back());
        end
        if (q.size() == 0)
            q.push_back(CH_W'($urandom_range(0, 255)));
        for (i = 0; i < q.size(); i++)
            send_char(i == 0, q[i]);
    endtask

    // result sink with random stalls
    initial
    begin : sink
        int hold;
        m_axis_tready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = gap_len();
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        int n;
        for (n = 0; n < CYCLE_LIMIT; n++)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int ph, goal;
        int base_tbl[5];
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_BASE_SELECT;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        items_sent    = 0;
        cur_base      = 0;
        cur_signed    = 1'b0;
        calm          = 1'b0;
        base_tbl      = '{0, 16, 1, 10, 8};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings (automatic base, unsigned)
        send_char(1'b0, "5");           // no string yet, ignored
        send_str("0x1F", 1'b1);         // hex prefix, NUL ends it
        send_str("07778", 1'b0);        // octal, stops at '8'
        send_str("0xg", 1'b0);          // pending prefix stops at the 'x'
        send_char(1'b0, "3");           // after the stop, ignored
        send_str("-7", 1'b0);           // lone minus in unsigned mode
        send_char(1'b1, 8'hFF);
        send_str("4294967296", 1'b0);   // wraps to zero

        // directed: signed hex, then a degenerate base
        set_mode(16, 1'b1);
        send_str("-fF", 1'b1);
        send_str("-0xa", 1'b0);
        set_mode(1, 1'b0);
        send_str("001", 1'b0);

        // random phases over several settings, extremes first
        goal = items_sent;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 5)
                set_mode(base_tbl[ph], ph[0]);
            else
                set_mode($urandom_range(0, 16), 1'($urandom_range(0, 1)));
            goal += TARGET_ITEMS / NUM_PHASES;
            while (items_sent < goal)
                random_string();
        end

        drain();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
src/aip_pkg.sv
src/aip_step.sv
src/ascii_integer_parser.sv
bench/aip_checker.sv
bench/tb_top.sv
